// ===== src/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, codes and phase step functions for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        PH_DATA        = 4'd0,
        PH_BIT_HIGH    = 4'd1,
        PH_BIT_LOW     = 4'd2,
        PH_ACK_HIGH    = 4'd3,
        PH_STOP_SETUP  = 4'd4,
        PH_STOP_HOLD   = 4'd5,
        PH_RECOVER     = 4'd6,
        PH_START_SETUP = 4'd7,
        PH_START_HOLD  = 4'd8,
        PH_RD_HIGH     = 4'd9,
        PH_RD_LOW      = 4'd10
    } phase_t;

    localparam int unsigned CFG_HOLD   = 0;
    localparam int unsigned CFG_SETTLE = 1;
    localparam int unsigned CFG_RETRY  = 2;

    typedef struct packed {
        cmd_t        cmd;
        phase_t      phase;
        logic [5:0]  tick_cnt;
        logic [3:0]  bit_cnt;
        logic [7:0]  shift;
        logic [2:0]  attempt;
        logic        scl_level;
        logic        sda_level;
        logic        last_nack;
        logic [7:0]  rx_last;
    } seq_state_t;

    typedef struct packed {
        seq_state_t st;
        logic       done;
    } step_res_t;

    function automatic seq_state_t enter_phase(seq_state_t s, phase_t p,
                                               logic [5:0] hold, logic [5:0] settle);
        seq_state_t r;
        logic [5:0] w;
        logic [2:0] idx;
        r = s;
        w = hold;
        idx = 3'd7 - s.bit_cnt[2:0];
        r.phase = p;
        unique case (p)
            PH_DATA: begin
                if (s.cmd == CMD_READ) begin
                    r.sda_level = s.attempt[0];
                end else begin
                    r.sda_level = s.shift[idx];
                end
                w = settle;
            end
            PH_BIT_HIGH:    r.scl_level = 1'b1;
            PH_BIT_LOW: begin
                r.scl_level = 1'b0;
                w = settle;
            end
            PH_ACK_HIGH:    r.scl_level = 1'b1;
            PH_STOP_SETUP: begin
                r.sda_level = 1'b0;
                r.scl_level = 1'b1;
            end
            PH_STOP_HOLD:   r.sda_level = 1'b1;
            PH_RECOVER:     r.sda_level = s.sda_level;
            PH_START_SETUP: begin
                r.sda_level = 1'b1;
                r.scl_level = 1'b1;
            end
            PH_START_HOLD:  r.sda_level = 1'b0;
            PH_RD_HIGH:     r.scl_level = 1'b1;
            PH_RD_LOW: begin
                r.scl_level = 1'b0;
                w = settle;
            end
            default:        r.phase = p;
        endcase
        r.tick_cnt = w;
        return r;
    endfunction

    function automatic seq_state_t finish_cmd(seq_state_t s);
        seq_state_t r;
        r = s;
        r.cmd = CMD_IDLE;
        r.phase = PH_DATA;
        r.tick_cnt = '0;
        return r;
    endfunction

    // Applies a new command, or counts a tick down, ahead of any phase ends.
    function automatic seq_state_t begin_item(seq_state_t s, logic [2:0] func,
                                              logic [7:0] wr_byte, logic ack_to_send,
                                              logic [5:0] hold, logic [5:0] settle);
        seq_state_t r;
        r = s;
        if (func == CMD_START || func == CMD_STOP || func == CMD_WRITE ||
            func == CMD_READ) begin
            if (s.cmd == CMD_IDLE) begin
                r.cmd = cmd_t'(func);
                r.bit_cnt = '0;
                r.attempt = '0;
                if (func == CMD_START) begin
                    r = enter_phase(r, PH_START_SETUP, hold, settle);
                end else if (func == CMD_STOP) begin
                    r = enter_phase(r, PH_STOP_SETUP, hold, settle);
                end else if (func == CMD_WRITE) begin
                    r.shift = wr_byte;
                    r = enter_phase(r, PH_DATA, hold, settle);
                end else begin
                    r.shift = '0;
                    r.attempt = {2'b00, ack_to_send};
                    r = enter_phase(r, PH_RD_HIGH, hold, settle);
                end
            end
        end else if (s.cmd != CMD_IDLE && s.tick_cnt != '0) begin
            r.tick_cnt = s.tick_cnt - 6'd1;
        end
        return r;
    endfunction

    function automatic step_res_t end_phase(seq_state_t s, logic sda,
                                            logic [5:0] hold, logic [5:0] settle,
                                            logic [2:0] retry);
        step_res_t  r;
        seq_state_t t;
        logic [2:0] lim;
        logic [3:0] nb;
        logic [2:0] na;
        lim = (retry == 3'd0) ? 3'd1 : retry;
        nb = s.bit_cnt + 4'd1;
        na = s.attempt + 3'd1;
        t = s;
        r.done = 1'b0;
        unique case (s.phase)
            PH_DATA:     t = enter_phase(s, PH_BIT_HIGH, hold, settle);
            PH_BIT_HIGH: t = enter_phase(s, PH_BIT_LOW, hold, settle);
            PH_BIT_LOW: begin
                if (s.cmd == CMD_READ) begin
                    t = finish_cmd(s);
                    r.done = 1'b1;
                end else begin
                    t.bit_cnt = nb;
                    t = enter_phase(t, nb[3] ? PH_ACK_HIGH : PH_DATA, hold, settle);
                end
            end
            PH_ACK_HIGH: begin
                t.scl_level = 1'b0;
                if (!sda) begin
                    t.last_nack = 1'b0;
                    t = finish_cmd(t);
                    r.done = 1'b1;
                end else begin
                    t = enter_phase(t, PH_STOP_SETUP, hold, settle);
                end
            end
            PH_STOP_SETUP: t = enter_phase(s, PH_STOP_HOLD, hold, settle);
            PH_STOP_HOLD: begin
                if (s.cmd == CMD_STOP) begin
                    t = finish_cmd(s);
                    r.done = 1'b1;
                end else begin
                    t = enter_phase(s, PH_RECOVER, hold, settle);
                end
            end
            PH_RECOVER:     t = enter_phase(s, PH_START_SETUP, hold, settle);
            PH_START_SETUP: t = enter_phase(s, PH_START_HOLD, hold, settle);
            PH_START_HOLD: begin
                t.scl_level = 1'b0;
                if (s.cmd == CMD_START) begin
                    t = finish_cmd(t);
                    r.done = 1'b1;
                end else begin
                    t.attempt = na;
                    if (na >= lim) begin
                        t.last_nack = 1'b1;
                        t = finish_cmd(t);
                        r.done = 1'b1;
                    end else begin
                        t.bit_cnt = '0;
                        t = enter_phase(t, PH_DATA, hold, settle);
                    end
                end
            end
            PH_RD_HIGH: begin
                t.shift = {s.shift[6:0], sda};
                t.scl_level = 1'b0;
                t = enter_phase(t, PH_RD_LOW, hold, settle);
            end
            PH_RD_LOW: begin
                t.bit_cnt = nb;
                if (nb[3]) begin
                    t.rx_last = s.shift;
                    t.bit_cnt = '0;
                    t = enter_phase(t, PH_DATA, hold, settle);
                end else begin
                    t = enter_phase(t, PH_RD_HIGH, hold, settle);
                end
            end
            default: begin
                t = finish_cmd(s);
                r.done = 1'b1;
            end
        endcase
        r.st = t;
        return r;
    endfunction

endpackage

// ===== src/i2c_master_bit_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// Open-drain I2C master: one beat per microsecond tick or command.
//
// Input beats: s_tuser carries the command (tick, start, stop, write, read),
// s_tdata the byte to send, the ACK bit to return and the sampled SDA level.
// Every input beat gives exactly one output beat with the SCL/SDA drive,
// busy/done flags, last received byte, write NACK status and a reject flag.
// A command sent while busy is dropped and flagged as rejected.
// A beat that ends at most one phase has its result registered in the output
// register (or the skid stage), and such beats can be taken every cycle while
// the skid stage is empty. A beat that ends more than one phase (zero-length
// waits chain them) ends one phase per cycle in the phase step unit, so
// s_tready stays low until its last phase has ended and its result is registered.
// The cfg channel writes hold_ticks (0), settle_ticks (1) and retry_limit
// (2) and is always ready; the user must use it only while idle, which the
// block does not enforce. Reset puts both lines released, the sequencer idle
// and the timing registers at 5, 1 and 3. When m_tready is low, one result is
// held in the output register and one more in a skid stage; s_tready then drops.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // wr_byte[7:0], ack_to_send, sda_in, zeros
    input  logic [2:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_release, sda_pull_low, busy_res,
                                   // done_res, rx_byte[7:0], nack, rejected, zeros
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    i2cms_pkg::seq_state_t st_reg, st_next, base, st_c;
    i2cms_pkg::step_res_t  step;
    logic        iter_reg, iter_next;
    logic        sda_hold_reg, sda_hold_next;
    logic        done_acc_reg, done_acc_next;
    logic [5:0]  hold_reg, settle_reg;
    logic [2:0]  retry_reg;
    logic        accept, go, more, sda_use, done_c, rej;
    logic        res_valid, input_mode;
    logic [15:0] res_data;
    logic        out_valid_reg, skid_valid_reg;
    logic [15:0] out_data_reg, skid_data_reg;
    logic        take;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !iter_reg && !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg   <= 6'd5;
            settle_reg <= 6'd1;
            retry_reg  <= 3'd3;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == 2'(i2cms_pkg::CFG_HOLD)) begin
                hold_reg <= cfg_data;
            end else if (cfg_index == 2'(i2cms_pkg::CFG_SETTLE)) begin
                settle_reg <= cfg_data;
            end else if (cfg_index == 2'(i2cms_pkg::CFG_RETRY)) begin
                retry_reg <= cfg_data[2:0];
            end
        end
    end

    always_comb begin
        base    = st_reg;
        sda_use = sda_hold_reg;
        done_c  = done_acc_reg;
        rej     = 1'b0;
        go      = 1'b0;
        if (iter_reg) begin
            go = 1'b1;
        end else if (accept) begin
            go      = 1'b1;
            sda_use = s_tdata[9];
            done_c  = 1'b0;
            rej     = (st_reg.cmd != i2cms_pkg::CMD_IDLE) &&
                      (s_tuser == i2cms_pkg::CMD_START || s_tuser == i2cms_pkg::CMD_STOP ||
                       s_tuser == i2cms_pkg::CMD_WRITE || s_tuser == i2cms_pkg::CMD_READ);
            base    = i2cms_pkg::begin_item(st_reg, s_tuser, s_tdata[7:0], s_tdata[8],
                                            hold_reg, settle_reg);
        end
        step = i2cms_pkg::end_phase(base, sda_use, hold_reg, settle_reg, retry_reg);
        st_c = base;
        if (base.cmd != i2cms_pkg::CMD_IDLE && base.tick_cnt == '0) begin
            st_c   = step.st;
            done_c = done_c | step.done;
        end
        more          = (st_c.cmd != i2cms_pkg::CMD_IDLE) && (st_c.tick_cnt == '0);
        st_next       = go ? st_c : st_reg;
        iter_next     = go && more;
        res_valid     = go && !more;
        done_acc_next = done_c;
        sda_hold_next = sda_use;
        input_mode = (st_c.cmd == i2cms_pkg::CMD_WRITE && st_c.phase == i2cms_pkg::PH_ACK_HIGH) ||
                     (st_c.cmd == i2cms_pkg::CMD_READ &&
                      (st_c.phase == i2cms_pkg::PH_RD_HIGH || st_c.phase == i2cms_pkg::PH_RD_LOW));
        res_data = {2'b00, rej, st_c.last_nack, st_c.rx_last, done_c,
                    st_c.cmd != i2cms_pkg::CMD_IDLE,
                    !input_mode && !st_c.sda_level, st_c.scl_level};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= '{cmd: i2cms_pkg::CMD_IDLE, phase: i2cms_pkg::PH_DATA,
                           tick_cnt: '0, bit_cnt: '0, shift: '0, attempt: '0,
                           scl_level: 1'b1, sda_level: 1'b1, last_nack: 1'b0,
                           rx_last: '0};
            iter_reg  <= 1'b0;
        end else begin
            st_reg    <= st_next;
            iter_reg  <= iter_next;
        end
        sda_hold_reg <= sda_hold_next;
        done_acc_reg <= done_acc_next;
    end

    // output register with skid stage
    assign take     = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= res_valid;
                skid_data_reg  <= res_data;
            end else begin
                out_valid_reg <= res_valid;
                out_data_reg  <= res_data;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= res_data;
        end
    end

endmodule

// ===== tb/sv/i2c_master_bit_sequencer_core_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core_tb
// Self-checking bench for the I2C master bit sequencer. Commands and ticks
// go in on the stream input with random gaps and output stalls. A line
// predictor models SCL/SDA drive, busy/done, received byte, write NACK and
// rejects, and every output beat is checked against it field by field.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  FN_TICK     = 3'd0;
    localparam logic [2:0]  FN_SPARE_LO = 3'd5;
    localparam logic [2:0]  FN_SPARE_HI = 3'd7;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned ITEMS_TOTAL = 1550;

    typedef enum logic [1:0] {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_t;

    typedef struct packed {
        logic       scl;
        logic       sda_low;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       nack;
        logic       rej;
    } line_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [5:0]  cfg_data  = '0;

    // predicted sequencer state and timing registers
    logic [5:0]        cfg_hold   = 6'd5;
    logic [5:0]        cfg_settle = 6'd1;
    logic [2:0]        cfg_retry  = 3'd3;
    i2cms_pkg::cmd_t   sq_cmd     = i2cms_pkg::CMD_IDLE;
    i2cms_pkg::phase_t sq_phase   = i2cms_pkg::PH_DATA;
    logic [5:0]        sq_ticks   = '0;
    logic [3:0]        sq_bits    = '0;
    logic [7:0]        sq_shift   = '0;
    logic [2:0]        sq_attempt = '0;
    logic              sq_scl     = 1'b1;
    logic              sq_sda     = 1'b1;
    logic              sq_nack    = 1'b0;
    logic [7:0]        sq_rx      = '0;

    line_beat_t  expected_lines[$];
    int unsigned mismatches   = 0;
    int unsigned beats_sent   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left   = 0;
    logic        src_steady   = 1'b0;
    logic        sink_steady  = 1'b0;

    i2c_master_bit_sequencer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void load_phase(i2cms_pkg::phase_t p);
        logic [5:0] wait_ticks;
        wait_ticks = cfg_hold;
        sq_phase = p;
        case (p)
            i2cms_pkg::PH_DATA: begin
                if (sq_cmd == i2cms_pkg::CMD_READ) begin
                    sq_sda = sq_attempt[0];
                end else begin
                    sq_sda = sq_shift[3'd7 - sq_bits[2:0]];
                end
                wait_ticks = cfg_settle;
            end
            i2cms_pkg::PH_BIT_HIGH, i2cms_pkg::PH_ACK_HIGH, i2cms_pkg::PH_RD_HIGH:
                sq_scl = 1'b1;
            i2cms_pkg::PH_BIT_LOW, i2cms_pkg::PH_RD_LOW: begin
                sq_scl = 1'b0;
                wait_ticks = cfg_settle;
            end
            i2cms_pkg::PH_STOP_SETUP: begin
                sq_sda = 1'b0;
                sq_scl = 1'b1;
            end
            i2cms_pkg::PH_STOP_HOLD:   sq_sda = 1'b1;
            i2cms_pkg::PH_START_SETUP: begin
                sq_sda = 1'b1;
                sq_scl = 1'b1;
            end
            i2cms_pkg::PH_START_HOLD:  sq_sda = 1'b0;
            default: ;
        endcase
        sq_ticks = wait_ticks;
    endfunction

    function automatic void go_idle();
        sq_cmd = i2cms_pkg::CMD_IDLE;
        sq_phase = i2cms_pkg::PH_DATA;
        sq_ticks = '0;
    endfunction

    // ends the current phase; 1 when the command completes
    function automatic logic close_phase(logic sda);
        logic [2:0] lim;
        logic       fin;
        lim = (cfg_retry == 3'd0) ? 3'd1 : cfg_retry;
        fin = 1'b0;
        case (sq_phase)
            i2cms_pkg::PH_DATA:     load_phase(i2cms_pkg::PH_BIT_HIGH);
            i2cms_pkg::PH_BIT_HIGH: load_phase(i2cms_pkg::PH_BIT_LOW);
            i2cms_pkg::PH_BIT_LOW: begin
                if (sq_cmd == i2cms_pkg::CMD_READ) begin
                    go_idle();
                    fin = 1'b1;
                end else begin
                    sq_bits = sq_bits + 4'd1;
                    if (sq_bits >= 4'd8) begin
                        load_phase(i2cms_pkg::PH_ACK_HIGH);
                    end else begin
                        load_phase(i2cms_pkg::PH_DATA);
                    end
                end
            end
            i2cms_pkg::PH_ACK_HIGH: begin
                sq_scl = 1'b0;
                if (!sda) begin
                    sq_nack = 1'b0;
                    go_idle();
                    fin = 1'b1;
                end else begin
                    load_phase(i2cms_pkg::PH_STOP_SETUP);
                end
            end
            i2cms_pkg::PH_STOP_SETUP: load_phase(i2cms_pkg::PH_STOP_HOLD);
            i2cms_pkg::PH_STOP_HOLD: begin
                if (sq_cmd == i2cms_pkg::CMD_STOP) begin
                    go_idle();
                    fin = 1'b1;
                end else begin
                    load_phase(i2cms_pkg::PH_RECOVER);
                end
            end
            i2cms_pkg::PH_RECOVER:     load_phase(i2cms_pkg::PH_START_SETUP);
            i2cms_pkg::PH_START_SETUP: load_phase(i2cms_pkg::PH_START_HOLD);
            i2cms_pkg::PH_START_HOLD: begin
                sq_scl = 1'b0;
                if (sq_cmd == i2cms_pkg::CMD_START) begin
                    go_idle();
                    fin = 1'b1;
                end else begin
                    sq_attempt = sq_attempt + 3'd1;
                    if (sq_attempt >= lim) begin
                        sq_nack = 1'b1;
                        go_idle();
                        fin = 1'b1;
                    end else begin
                        sq_bits = '0;
                        load_phase(i2cms_pkg::PH_DATA);
                    end
                end
            end
            i2cms_pkg::PH_RD_HIGH: begin
                sq_shift = {sq_shift[6:0], sda};
                sq_scl = 1'b0;
                load_phase(i2cms_pkg::PH_RD_LOW);
            end
            i2cms_pkg::PH_RD_LOW: begin
                sq_bits = sq_bits + 4'd1;
                if (sq_bits >= 4'd8) begin
                    sq_rx = sq_shift;
                    sq_bits = '0;
                    load_phase(i2cms_pkg::PH_DATA);
                end else begin
                    load_phase(i2cms_pkg::PH_RD_HIGH);
                end
            end
            default: begin
                go_idle();
                fin = 1'b1;
            end
        endcase
        return fin;
    endfunction

    function automatic logic run_phases(logic sda);
        logic fin;
        fin = 1'b0;
        while (sq_cmd != i2cms_pkg::CMD_IDLE && sq_ticks == 6'd0) begin
            if (close_phase(sda)) fin = 1'b1;
        end
        return fin;
    endfunction

    function automatic line_beat_t predict_lines(logic [2:0] func, logic [7:0] wr,
                                                 logic ack, logic sda);
        line_beat_t r;
        logic       listening;
        r = '0;
        if (func >= i2cms_pkg::CMD_START && func <= i2cms_pkg::CMD_READ) begin
            if (sq_cmd != i2cms_pkg::CMD_IDLE) begin
                r.rej = 1'b1;
            end else begin
                sq_cmd = i2cms_pkg::cmd_t'(func);
                sq_bits = '0;
                sq_attempt = '0;
                case (sq_cmd)
                    i2cms_pkg::CMD_START: load_phase(i2cms_pkg::PH_START_SETUP);
                    i2cms_pkg::CMD_STOP:  load_phase(i2cms_pkg::PH_STOP_SETUP);
                    i2cms_pkg::CMD_WRITE: begin
                        sq_shift = wr;
                        load_phase(i2cms_pkg::PH_DATA);
                    end
                    default: begin
                        sq_shift = '0;
                        sq_attempt = {2'b00, ack};
                        load_phase(i2cms_pkg::PH_RD_HIGH);
                    end
                endcase
                r.done = run_phases(sda);
            end
        end else if (sq_cmd != i2cms_pkg::CMD_IDLE) begin
            if (sq_ticks != 6'd0) sq_ticks = sq_ticks - 6'd1;
            r.done = run_phases(sda);
        end
        listening = (sq_cmd == i2cms_pkg::CMD_WRITE && sq_phase == i2cms_pkg::PH_ACK_HIGH) ||
                    (sq_cmd == i2cms_pkg::CMD_READ &&
                     (sq_phase == i2cms_pkg::PH_RD_HIGH || sq_phase == i2cms_pkg::PH_RD_LOW));
        r.scl = sq_scl;
        r.sda_low = !listening && !sq_sda;
        r.busy = sq_cmd != i2cms_pkg::CMD_IDLE;
        r.rx = sq_rx;
        r.nack = sq_nack;
        return r;
    endfunction

    function automatic logic line_level(sda_mode_t mode);
        if (mode == SDA_LOW) return 1'b0;
        if (mode == SDA_HIGH) return 1'b1;
        return 1'($urandom);
    endfunction

    function automatic sda_mode_t pick_mode();
        int unsigned roll;
        roll = $urandom_range(0, 3);
        if (roll == 0) return SDA_LOW;
        if (roll == 1) return SDA_HIGH;
        return SDA_RANDOM;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: mismatch on %s, got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge aclk) begin
        line_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lines.size() == 0) begin
                report_mismatch("unexpected beat", 32'(m_tdata), 0);
            end else begin
                want = expected_lines.pop_front();
                if (m_tdata[0] !== want.scl)
                    report_mismatch("scl_release", 32'(m_tdata[0]), 32'(want.scl));
                if (m_tdata[1] !== want.sda_low)
                    report_mismatch("sda_pull_low", 32'(m_tdata[1]), 32'(want.sda_low));
                if (m_tdata[2] !== want.busy)
                    report_mismatch("busy", 32'(m_tdata[2]), 32'(want.busy));
                if (m_tdata[3] !== want.done)
                    report_mismatch("done", 32'(m_tdata[3]), 32'(want.done));
                if (m_tdata[11:4] !== want.rx)
                    report_mismatch("rx_byte", 32'(m_tdata[11:4]), 32'(want.rx));
                if (m_tdata[12] !== want.nack)
                    report_mismatch("nack", 32'(m_tdata[12]), 32'(want.nack));
                if (m_tdata[13] !== want.rej)
                    report_mismatch("rejected", 32'(m_tdata[13]), 32'(want.rej));
            end
        end
    end

    // output back-pressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!sink_steady && $urandom_range(0, 99) < 15) begin
            stall_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("i2c_master_bit_sequencer_core_tb failed");
            $finish;
        end
    end

    task automatic send_beat(logic [2:0] func, logic [7:0] wr, logic ack, logic sda);
        int unsigned gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {6'b0, sda, ack, wr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_lines.push_back(predict_lines(func, wr, ack, sda));
        beats_sent++;
    endtask

    // hold the input until every expected beat is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_timing(logic [5:0] hold, logic [5:0] settle, logic [2:0] retry);
        int unsigned idx;
        logic [5:0]  val;
        wait_idle();
        for (idx = 0; idx < 3; idx++) begin
            if (idx == i2cms_pkg::CFG_HOLD) val = hold;
            else if (idx == i2cms_pkg::CFG_SETTLE) val = settle;
            else val = {3'b000, retry};
            cfg_valid <= 1'b1;
            cfg_index <= 2'(idx);
            cfg_data <= val;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            if (idx == i2cms_pkg::CFG_HOLD) cfg_hold = val;
            else if (idx == i2cms_pkg::CFG_SETTLE) cfg_settle = val;
            else cfg_retry = val[2:0];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic tick_until_idle(sda_mode_t mode, int unsigned noise_pct);
        int unsigned roll;
        while (sq_cmd != i2cms_pkg::CMD_IDLE) begin
            roll = $urandom_range(0, 99);
            if (roll < noise_pct)
                send_beat(3'($urandom_range(i2cms_pkg::CMD_START, i2cms_pkg::CMD_READ)),
                          8'($urandom), 1'($urandom), line_level(mode));
            else if (roll < 2 * noise_pct)
                send_beat(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), 8'($urandom),
                          1'($urandom), line_level(mode));
            else
                send_beat(FN_TICK, 8'($urandom), 1'($urandom), line_level(mode));
        end
    endtask

    task automatic run_command(i2cms_pkg::cmd_t cmd, logic [7:0] wr, logic ack,
                               sda_mode_t mode, int unsigned noise_pct);
        send_beat(cmd, wr, ack, line_level(mode));
        tick_until_idle(mode, noise_pct);
    endtask

    task automatic test_idle_lines();
        send_beat(FN_TICK, 8'h00, 1'b0, 1'b0);
        send_beat(FN_SPARE_LO, 8'hFF, 1'b1, 1'b1);
        send_beat(3'd6, 8'h5A, 1'b0, 1'b1);
        send_beat(FN_SPARE_HI, 8'hA5, 1'b1, 1'b0);
    endtask

    task automatic test_reset_timing();
        run_command(i2cms_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(i2cms_pkg::CMD_WRITE, 8'hA5, 1'b0, SDA_LOW, 0);
        run_command(i2cms_pkg::CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH, 0);
        run_command(i2cms_pkg::CMD_WRITE, 8'h00, 1'b0, SDA_LOW, 0);
        run_command(i2cms_pkg::CMD_READ, 8'h00, 1'b0, SDA_HIGH, 0);
        run_command(i2cms_pkg::CMD_READ, 8'hFF, 1'b1, SDA_LOW, 0);
        run_command(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
    endtask

    task automatic test_busy_rejects();
        send_beat(i2cms_pkg::CMD_START, 8'h00, 1'b0, 1'b1);
        send_beat(i2cms_pkg::CMD_WRITE, 8'h3C, 1'b1, 1'b0);
        send_beat(i2cms_pkg::CMD_READ, 8'h00, 1'b1, 1'b1);
        send_beat(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
        send_beat(i2cms_pkg::CMD_START, 8'h00, 1'b0, 1'b1);
        send_beat(FN_SPARE_LO, 8'h00, 1'b0, 1'b1);
        tick_until_idle(SDA_RANDOM, 0);
        send_beat(i2cms_pkg::CMD_WRITE, 8'hC3, 1'b0, 1'b1);
        tick_until_idle(SDA_RANDOM, 30);
    endtask

    task automatic test_fast_timing();
        // zero settle and a zero retry limit: a single write attempt
        set_timing(6'd1, 6'd0, 3'd0);
        run_command(i2cms_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(i2cms_pkg::CMD_WRITE, 8'h3C, 1'b0, SDA_HIGH, 0);
        run_command(i2cms_pkg::CMD_WRITE, 8'h81, 1'b1, SDA_LOW, 0);
        run_command(i2cms_pkg::CMD_READ, 8'h00, 1'b1, SDA_RANDOM, 0);
        run_command(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
        set_timing(6'd1, 6'd0, 3'd7);
        run_command(i2cms_pkg::CMD_WRITE, 8'hFF, 1'b0, SDA_HIGH, 0);
    endtask

    task automatic test_extreme_timing();
        set_timing(6'd63, 6'd0, 3'd7);
        run_command(i2cms_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
    endtask

    task automatic test_random_traffic(int unsigned total_beats);
        int unsigned cmds;
        int unsigned k;
        int unsigned roll;
        while (beats_sent < total_beats) begin
            if ($urandom_range(0, 9) == 0)
                set_timing(6'($urandom_range(1, 12)), 6'($urandom_range(0, 12)),
                           3'($urandom_range(0, 7)));
            else
                set_timing(6'($urandom_range(1, 3)), 6'($urandom_range(0, 2)),
                           3'($urandom_range(0, 7)));
            src_steady = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            cmds = $urandom_range(4, 10);
            for (k = 0; k < cmds && beats_sent < total_beats; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    send_beat(3'($urandom_range(FN_TICK, FN_SPARE_HI)), 8'($urandom),
                              1'($urandom), 1'($urandom));
                else
                    run_command(i2cms_pkg::cmd_t'($urandom_range(i2cms_pkg::CMD_START,
                                                                 i2cms_pkg::CMD_READ)),
                                8'($urandom), 1'($urandom), pick_mode(), 4);
            end
        end
        src_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_lines();
        test_reset_timing();
        test_busy_rejects();
        test_fast_timing();
        test_extreme_timing();
        test_random_traffic(ITEMS_TOTAL);
        wait_idle();
        if (mismatches == 0) begin
            $display("i2c_master_bit_sequencer_core_tb passed");
        end else begin
            $display("i2c_master_bit_sequencer_core_tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/i2cms_pkg.sv
src/i2c_master_bit_sequencer_core.sv
tb/sv/i2c_master_bit_sequencer_core_tb.sv
